### hdl/framebuffer_clipped_draw_engine_assert.svh
// Assertion macros used by the draw engine top level.
// Each macro expands to one labeled concurrent assertion on a clock and a reset.
`ifndef FRAMEBUFFER_CLIPPED_DRAW_ENGINE_ASSERT_SVH
`define FRAMEBUFFER_CLIPPED_DRAW_ENGINE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FCDE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("draw engine check failed");

// Consequent must hold in the cycle after the antecedent.
`define FCDE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("draw engine check failed");

`endif

### hdl/fcde_pkg.sv
// Shared types and codes for the clipped draw engine.
// No dependencies; imported by fcde_clip and the top level.
`timescale 1ns / 1ps

package fcde_pkg;

   localparam int COORD_W = 18;

   typedef logic [2:0] fcde_action_type;

   localparam fcde_action_type ACT_SET_PIXEL    = 3'd0;
   localparam fcde_action_type ACT_READ_PIXEL   = 3'd1;
   localparam fcde_action_type ACT_HLINE        = 3'd2;
   localparam fcde_action_type ACT_VLINE        = 3'd3;
   localparam fcde_action_type ACT_FILL_RECT    = 3'd4;
   localparam fcde_action_type ACT_OUTLINE_RECT = 3'd5;
   localparam fcde_action_type ACT_FILL_SCREEN  = 3'd6;

   typedef logic [1:0] fcde_seg_type;

   localparam fcde_seg_type SEG_TOP    = 2'd0;
   localparam fcde_seg_type SEG_BOTTOM = 2'd1;
   localparam fcde_seg_type SEG_LEFT   = 2'd2;
   localparam fcde_seg_type SEG_RIGHT  = 2'd3;

   // Clipped box for one drawing segment, inclusive bounds.
   typedef struct packed {
      logic                       empty;
      logic signed [COORD_W-1:0]  x0;
      logic signed [COORD_W-1:0]  x_last;
      logic signed [COORD_W-1:0]  y0;
      logic signed [COORD_W-1:0]  y_last;
   } fcde_box_type;

endpackage

### hdl/framebuffer_clipped_draw_engine.sv
// Clipped draw engine over an 8-bit frame store: command sequencer and top level.
// Depends on fcde_pkg, fcde_clip, fcde_ram and the assertion header.
//
// One command is taken at a time; req_tready is high only while the engine is
// idle. Each drawing segment is clipped, then its row base is multiplied, then
// one visible pixel is written per cycle, then the next segment is picked; a
// command ends by loading the result register, which waits while an earlier
// result is held and not taken. An outline runs these steps for each of its
// edges, top, bottom, left and right; a clipped-away segment goes from clip
// straight to picking the next. Read pixel waits for the store's registered
// read. Fill screen writes every pixel, one per cycle. After reset the store
// is cleared by the same sweep, in which no command is taken. The result
// register lets the next command start while a result waits.
`timescale 1ns / 1ps
`include "framebuffer_clipped_draw_engine_assert.svh"

module framebuffer_clipped_draw_engine #(
   parameter int SCREEN_WIDTH  = 128,
   parameter int SCREEN_HEIGHT = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // pos_x [15:0], pos_y [31:16], span_width [47:32], span_height [63:48],
   // colour [71:64]
   input  logic [71:0] req_tdata,
   // action [2:0]
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // pixel_value [7:0]
   output logic [7:0]  rsp_tdata,
   // on_screen [0]
   output logic        rsp_tuser
);

   import fcde_pkg::*;

   localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(SCREEN_WIDTH + 1);
   localparam int RW    = $clog2(SCREEN_HEIGHT + 1);
   localparam logic [AW-1:0] W_A = AW'(SCREEN_WIDTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_MULT,
      ST_DRAW,
      ST_NEXT,
      ST_READ,
      ST_RWAIT,
      ST_DONE
   } state_type;

   state_type           state_ff;
   fcde_action_type     action_ff;
   logic signed [15:0]  pos_x_ff, pos_y_ff;
   logic [15:0]         span_width_ff, span_height_ff;
   logic [7:0]          colour_ff;
   fcde_seg_type        seg_ff;
   logic                init_ff;
   logic [CW-1:0]       col_ff, x0_ff, xl_ff;
   logic [RW-1:0]       row_ff, yl_ff;
   logic [AW-1:0]       base_ff;
   logic [7:0]          res_value_ff;
   logic                res_vis_ff;
   logic                rsp_tvalid_ff;
   logic [7:0]          rsp_tdata_ff;
   logic                rsp_tuser_ff;

   fcde_box_type        box;
   logic [AW-1:0]       pix_addr;
   logic                wr_en, rd_en;
   logic [7:0]          rd_data;
   logic                req_xfer;
   logic                row_end, box_end;
   logic                rsp_load;

   fcde_clip #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_clip (
      .action      (action_ff),
      .pos_x       (pos_x_ff),
      .pos_y       (pos_y_ff),
      .span_width  (span_width_ff),
      .span_height (span_height_ff),
      .seg         (seg_ff),
      .box         (box)
   );

   fcde_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (pix_addr),
      .wr_data (colour_ff),
      .rd_en   (rd_en),
      .rd_addr (pix_addr),
      .rd_data (rd_data)
   );

   assign pix_addr   = base_ff + AW'(col_ff);
   assign wr_en      = (state_ff == ST_DRAW);
   assign rd_en      = (state_ff == ST_READ);
   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign row_end    = (col_ff == xl_ff);
   assign box_end    = row_end && (row_ff == yl_ff);
   // Load a new result once the output register is empty or being drained.
   assign rsp_load   = (state_ff == ST_DONE) && !init_ff && (!rsp_tvalid_ff || rsp_tready);

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         // Clear the store with a fill-screen sweep in colour zero.
         state_ff      <= ST_SETUP;
         action_ff     <= ACT_FILL_SCREEN;
         colour_ff     <= 8'd0;
         seg_ff        <= SEG_TOP;
         init_ff       <= 1'b1;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (rsp_tvalid_ff && rsp_tready && !rsp_load) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  action_ff      <= req_tuser;
                  pos_x_ff       <= req_tdata[15:0];
                  pos_y_ff       <= req_tdata[31:16];
                  span_width_ff  <= req_tdata[47:32];
                  span_height_ff <= req_tdata[63:48];
                  colour_ff      <= req_tdata[71:64];
                  seg_ff         <= SEG_TOP;
                  res_value_ff   <= 8'd0;
                  res_vis_ff     <= 1'b0;
                  state_ff       <= ST_SETUP;
               end
            end
            ST_SETUP: begin
               x0_ff    <= box.x0[CW-1:0];
               col_ff   <= box.x0[CW-1:0];
               xl_ff    <= box.x_last[CW-1:0];
               row_ff   <= box.y0[RW-1:0];
               yl_ff    <= box.y_last[RW-1:0];
               state_ff <= box.empty ? ST_NEXT : ST_MULT;
            end
            ST_MULT: begin
               base_ff  <= AW'(row_ff) * W_A;
               state_ff <= (action_ff == ACT_READ_PIXEL) ? ST_READ : ST_DRAW;
            end
            ST_DRAW: begin
               if (box_end) begin
                  state_ff <= ST_NEXT;
               end else if (row_end) begin
                  col_ff  <= x0_ff;
                  row_ff  <= row_ff + 1'b1;
                  base_ff <= base_ff + W_A;
               end else begin
                  col_ff <= col_ff + 1'b1;
               end
            end
            ST_NEXT: begin
               if ((action_ff == ACT_OUTLINE_RECT) && (seg_ff != SEG_RIGHT)) begin
                  seg_ff   <= seg_ff + 1'b1;
                  state_ff <= ST_SETUP;
               end else begin
                  state_ff <= ST_DONE;
               end
            end
            ST_READ: begin
               state_ff <= ST_RWAIT;
            end
            ST_RWAIT: begin
               res_value_ff <= rd_data;
               res_vis_ff   <= 1'b1;
               state_ff     <= ST_DONE;
            end
            ST_DONE: begin
               if (init_ff) begin
                  init_ff  <= 1'b0;
                  state_ff <= ST_IDLE;
               end else if (rsp_load) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tdata_ff  <= res_value_ff;
                  rsp_tuser_ff  <= res_vis_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   `FCDE_ASSERT_IMPL(a_wr_in_range, clock, reset, wr_en, pix_addr <= AW'(DEPTH - 1))
   `FCDE_ASSERT_IMPL(a_draw_bounds, clock, reset, state_ff == ST_DRAW, col_ff <= xl_ff && row_ff <= yl_ff)
   `FCDE_ASSERT_IMPL(a_no_rsp_in_init, clock, reset, init_ff, !rsp_tvalid_ff && !req_tready)
   `FCDE_ASSERT_IMPL(a_off_screen_zero, clock, reset, rsp_tvalid_ff && !rsp_tuser_ff, rsp_tdata_ff == 8'd0)
   `FCDE_ASSERT_NEXT(a_busy_after_take, clock, reset, req_xfer, state_ff == ST_SETUP)

endmodule

### hdl/fcde_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the frame store of the draw engine.
`timescale 1ns / 1ps

module fcde_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16384,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/fcde_clip.sv
// Segment selection and screen clipping for the draw engine.
// Depends on fcde_pkg; turns a command and a segment number into a clipped box.
`timescale 1ns / 1ps

module fcde_clip #(
   parameter int SCREEN_WIDTH  = 128,
   parameter int SCREEN_HEIGHT = 128
) (
   input  fcde_pkg::fcde_action_type action,
   input  logic signed [15:0]        pos_x,
   input  logic signed [15:0]        pos_y,
   input  logic [15:0]               span_width,
   input  logic [15:0]               span_height,
   input  fcde_pkg::fcde_seg_type    seg,
   output fcde_pkg::fcde_box_type    box
);

   import fcde_pkg::*;

   localparam logic signed [COORD_W-1:0] W_S = COORD_W'(SCREEN_WIDTH);
   localparam logic signed [COORD_W-1:0] H_S = COORD_W'(SCREEN_HEIGHT);
   localparam logic signed [COORD_W-1:0] ONE = COORD_W'(1);
   localparam logic signed [COORD_W-1:0] ZERO = '0;

   logic signed [COORD_W-1:0] px, py, pw, ph;
   logic signed [COORD_W-1:0] sx, sy, sw, sh;
   logic signed [COORD_W-1:0] x_end, y_end, x0, y0, x1, y1;
   logic                      no_area;

   always_comb begin
      px = {{2{pos_x[15]}}, pos_x};
      py = {{2{pos_y[15]}}, pos_y};
      pw = {2'b00, span_width};
      ph = {2'b00, span_height};
      sx = px;
      sy = py;
      sw = ONE;
      sh = ONE;
      no_area = 1'b0;
      case (action)
         ACT_SET_PIXEL, ACT_READ_PIXEL: begin
         end
         ACT_HLINE: begin
            sw = pw;
         end
         ACT_VLINE: begin
            sh = ph;
         end
         ACT_FILL_RECT: begin
            sw = pw;
            sh = ph;
         end
         ACT_OUTLINE_RECT: begin
            // Every edge is skipped when either size is zero.
            no_area = (span_width == 16'd0) || (span_height == 16'd0);
            case (seg)
               SEG_TOP: begin
                  sw = pw;
               end
               SEG_BOTTOM: begin
                  sy = py + ph - ONE;
                  sw = pw;
               end
               SEG_LEFT: begin
                  sh = ph;
               end
               default: begin
                  sx = px + pw - ONE;
                  sh = ph;
               end
            endcase
         end
         ACT_FILL_SCREEN: begin
            sx = ZERO;
            sy = ZERO;
            sw = W_S;
            sh = H_S;
         end
         default: begin
            no_area = 1'b1;
         end
      endcase

      x_end = sx + sw;
      y_end = sy + sh;
      x0 = (sx < ZERO) ? ZERO : sx;
      y0 = (sy < ZERO) ? ZERO : sy;
      x1 = (x_end > W_S) ? W_S : x_end;
      y1 = (y_end > H_S) ? H_S : y_end;

      box.empty  = no_area || (x0 >= x1) || (y0 >= y1);
      box.x0     = x0;
      box.x_last = x1 - ONE;
      box.y0     = y0;
      box.y_last = y1 - ONE;
   end

endmodule
